/* hw/rtl/fdl_pkg.sv */
// Shared constants and types for the fractional delay line.
package fdl_pkg;

  // Default geometry of the ring and the sample format.
  localparam int MAX_DEPTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  // Smallest ring length that the block runs with.
  localparam int MIN_LENGTH = 2;

  // Forwarding flags that go with a pair of tap reads. A flag is set when
  // the tap hits the entry that the same beat wrote during the read cycle.
  typedef struct packed {
    logic fwd_a;
    logic fwd_b;
  } fdl_fwd_t;

endpackage

/* hw/rtl/fractional_delay_line_lerp_core.sv */
// Top level of the fractional delay line with linear interpolation.
// Each input beat writes one sample into a ring of MAX_DEPTH entries and
// returns A + frac*(B-A), where A and B are the taps at the integer delay and
// one sample further back; the delay has FRAC_BITS fraction bits and
// saturates to buffer_length-1. The block takes one beat per clock while the
// output is not stalled: the ring is one memory with a write port and two
// registered read ports, so a beat's write and both tap reads happen in the
// same cycle, and a tap on the entry just written is forwarded. A result passes
// the input register, the read stage and the multiply stage to the output
// register. After reset the block clears every ring entry with in_ready low;
// buffer_length can be written during that time. Write buffer_length only while
// no beat is in flight.
module fractional_delay_line_lerp_core #(
  parameter int MAX_DEPTH   = fdl_pkg::MAX_DEPTH_DEF,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_we,
  input  logic [$clog2(MAX_DEPTH+1)-1:0]                  cfg_wdata,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]                   sample_in,
  input  logic [$clog2(MAX_DEPTH)+FRAC_BITS-1:0]          delay_amount,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]                   sample_out
);

  import fdl_pkg::*;

  localparam int ADDR_W  = $clog2(MAX_DEPTH);
  localparam int LEN_W   = $clog2(MAX_DEPTH + 1);
  localparam int DELAY_W = ADDR_W + FRAC_BITS;

  // Configuration and pointer state.
  logic [LEN_W-1:0]  len_act;
  logic [ADDR_W-1:0] wp;

  // Clearing pass.
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // Input register stage.
  logic                          v1;
  logic signed [SAMPLE_BITS-1:0] smp1;
  logic [ADDR_W-1:0]             whole1;
  logic [FRAC_BITS-1:0]          frac1;

  // Read stage.
  logic                          v2;
  logic signed [SAMPLE_BITS-1:0] smp2;
  logic [FRAC_BITS-1:0]          frac2;
  fdl_fwd_t                      fwd2;
  logic signed [SAMPLE_BITS-1:0] rd_a;
  logic signed [SAMPLE_BITS-1:0] rd_b;

  // Ring memory.
  logic signed [SAMPLE_BITS-1:0] mem [MAX_DEPTH];

  logic              in_take;
  logic              adv1;
  logic              tap_ready;
  logic              adv2;
  logic [ADDR_W-1:0] whole_raw;
  logic              sat;
  logic [LEN_W-1:0]  wp_inc;
  logic [ADDR_W-1:0] nxt;
  logic [LEN_W:0]    d_a;
  logic [LEN_W:0]    d_b;
  logic [LEN_W:0]    len_ext;
  logic [LEN_W:0]    ia_full;
  logic [LEN_W:0]    ib_full;
  logic [ADDR_W-1:0] ia;
  logic [ADDR_W-1:0] ib;
  logic [LEN_W-1:0]  len_m1;

  // Stage handshakes.
  assign adv2     = v2 && tap_ready;
  assign adv1     = v1 && (!v2 || tap_ready);
  assign in_ready = !clearing && (!v1 || adv1);
  assign in_take  = in_valid && in_ready;

  // Active length: out-of-range writes are clamped to the legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_act <= LEN_W'(MAX_DEPTH);
    end else if (cfg_we) begin
      if (cfg_wdata < LEN_W'(MIN_LENGTH)) begin
        len_act <= LEN_W'(MIN_LENGTH);
      end else if (cfg_wdata > LEN_W'(MAX_DEPTH)) begin
        len_act <= LEN_W'(MAX_DEPTH);
      end else begin
        len_act <= cfg_wdata;
      end
    end
  end

  // Clearing pass over the whole ring after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MAX_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Delay saturation at capture: an integer part at or above length-1
  // becomes exactly length-1 with a zero fraction.
  assign len_m1    = len_act - 1'b1;
  assign whole_raw = delay_amount[DELAY_W-1:FRAC_BITS];
  assign sat       = {{(LEN_W-ADDR_W){1'b0}}, whole_raw} >= len_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_take) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp1   <= sample_in;
      whole1 <= sat ? len_m1[ADDR_W-1:0] : whole_raw;
      frac1  <= sat ? '0 : delay_amount[FRAC_BITS-1:0];
    end
  end

  // Next write position, wrapping at the active length.
  assign wp_inc = {{(LEN_W-ADDR_W){1'b0}}, wp} + 1'b1;
  assign nxt    = (wp_inc >= len_act) ? '0 : wp_inc[ADDR_W-1:0];

  // Tap addresses modulo the active length, both computed from the new position.
  assign len_ext = {1'b0, len_act};
  assign d_a     = {{(LEN_W+1-ADDR_W){1'b0}}, nxt} - {{(LEN_W+1-ADDR_W){1'b0}}, whole1};
  assign d_b     = d_a - 1'b1;
  assign ia_full = d_a[LEN_W] ? d_a + len_ext : d_a;
  assign ib_full = d_b[LEN_W] ? d_b + len_ext : d_b;
  assign ia      = ia_full[ADDR_W-1:0];
  assign ib      = ib_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= ADDR_W'(MAX_DEPTH - 1);
    end else if (adv1) begin
      wp <= nxt;
    end
  end

  // Ring memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (adv1) begin
      mem[nxt] <= smp1;
    end
    if (adv1) begin
      rd_a <= mem[ia];
      rd_b <= mem[ib];
    end
  end

  // Read stage: the sample and forwarding flags travel with the tap data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv1) begin
      v2 <= 1'b1;
    end else if (adv2) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      smp2       <= smp1;
      frac2      <= frac1;
      fwd2.fwd_a <= (ia == nxt);
      fwd2.fwd_b <= (ib == nxt);
    end
  end

  // Interpolation and output register.
  fdl_lerp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lerp (
    .clk        (clk),
    .rst        (rst),
    .tap_valid  (v2),
    .tap_ready  (tap_ready),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .new_sample (smp2),
    .frac       (frac2),
    .fwd        (fwd2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

endmodule

/* hw/rtl/fdl_lerp.sv */
// Interpolation pipeline: tap forwarding, multiply stage and output register.
module fdl_lerp #(
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tap_valid,
  output logic                          tap_ready,
  input  logic signed [SAMPLE_BITS-1:0] rd_a,
  input  logic signed [SAMPLE_BITS-1:0] rd_b,
  input  logic signed [SAMPLE_BITS-1:0] new_sample,
  input  logic        [FRAC_BITS-1:0]   frac,
  input  fdl_pkg::fdl_fwd_t             fwd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int PROD_W = FRAC_BITS + SAMPLE_BITS + 2;

  logic                          take;
  logic                          adv3;
  logic signed [SAMPLE_BITS-1:0] tap_a;
  logic signed [SAMPLE_BITS-1:0] tap_b;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_W-1:0]      prod;
  logic                          v3;
  logic signed [PROD_W-1:0]      prod3;
  logic signed [SAMPLE_BITS-1:0] a3;
  logic        [SAMPLE_BITS+1:0] sum;

  // Stage handshakes: the multiply stage moves on when the output register frees up.
  assign adv3      = v3 && (!out_valid || out_ready);
  assign tap_ready = !v3 || adv3;
  assign take      = tap_valid && tap_ready;

  // A tap that hit the entry written in the read cycle takes the new sample.
  assign tap_a = fwd.fwd_a ? new_sample : rd_a;
  assign tap_b = fwd.fwd_b ? new_sample : rd_b;

  // Exact product of the fraction and the tap difference.
  assign diff = $signed({tap_b[SAMPLE_BITS-1], tap_b}) - $signed({tap_a[SAMPLE_BITS-1], tap_a});
  assign prod = PROD_W'($signed({1'b0, frac})) * PROD_W'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (take) begin
      v3 <= 1'b1;
    end else if (adv3) begin
      v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod3 <= prod;
      a3    <= tap_a;
    end
  end

  // The upper product bits are the arithmetic shift, which floors. The sum
  // lies between the two taps, so the low bits are the full result.
  assign sum = {{2{a3[SAMPLE_BITS-1]}}, a3} + prod3[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      sample_out <= sum[SAMPLE_BITS-1:0];
    end
  end

endmodule

/* sim/fractional_delay_line_lerp_core_test.sv */
// Self-checking testbench for the fractional delay line with linear interpolation.
`timescale 1ns / 100ps

module fractional_delay_line_lerp_core_test;

  localparam int MAX_DEPTH   = fdl_pkg::MAX_DEPTH_DEF;
  localparam int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF;
  localparam int LEN_BITS    = $clog2(MAX_DEPTH + 1);
  localparam int DELAY_BITS  = $clog2(MAX_DEPTH) + FRAC_BITS;
  localparam int WHOLE_BITS  = DELAY_BITS - FRAC_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [FRAC_BITS-1:0]          FRAC_FULL  = {FRAC_BITS{1'b1}};
  localparam logic [FRAC_BITS-1:0]          FRAC_HALF  = {1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic [DELAY_BITS-1:0]         DELAY_ALL  = {DELAY_BITS{1'b1}};

  // Four pipeline stages plus margin; used before length writes and at the end.
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [DELAY_BITS-1:0]         dly;
  } delay_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [LEN_BITS-1:0]           cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic [DELAY_BITS-1:0]         delay_amount = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  fractional_delay_line_lerp_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_in    (sample_in),
    .delay_amount (delay_amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Beats waiting to be driven and interpolated samples waiting to come out.
  delay_beat_t                   pending_beats[$];
  logic signed [SAMPLE_BITS-1:0] expected_samples[$];

  // Shadow copy of the ring, its write position and the length register.
  logic signed [SAMPLE_BITS-1:0] ring_shadow[MAX_DEPTH];
  int unsigned                   wr_pos_shadow;
  logic [LEN_BITS-1:0]           length_shadow;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned length_writes = 0;
  logic        in_fired = 1'b0;

  // Length in use after clamping to the legal range.
  function automatic int unsigned clamp_length(input logic [LEN_BITS-1:0] raw);
    if (int'(raw) < fdl_pkg::MIN_LENGTH) return fdl_pkg::MIN_LENGTH;
    if (int'(raw) > MAX_DEPTH) return MAX_DEPTH;
    return int'(raw);
  endfunction

  // Writes one sample into the shadow ring and returns the sample interpolated between the tap pair.
  function automatic logic signed [SAMPLE_BITS-1:0] interpolate_tap(
      input logic signed [SAMPLE_BITS-1:0] smp, input logic [DELAY_BITS-1:0] dly);
    int unsigned len_eff;
    int unsigned nxt;
    int unsigned whole;
    int unsigned tap_a;
    int unsigned tap_b;
    longint      dly_sat;
    longint      dly_top;
    longint      frac;
    longint      near_val;
    longint      far_val;
    longint      prod;
    longint      res;
    len_eff = clamp_length(length_shadow);
    nxt = wr_pos_shadow + 1;
    if (nxt >= len_eff) nxt = 0;
    wr_pos_shadow = nxt;
    ring_shadow[nxt] = smp;

    // Saturate the whole delay to (length-1).0.
    dly_top = longint'(len_eff - 1) << FRAC_BITS;
    dly_sat = longint'(dly);
    if (dly_sat > dly_top) dly_sat = dly_top;
    whole = int'(dly_sat >> FRAC_BITS);
    frac  = dly_sat & ((longint'(1) << FRAC_BITS) - 1);

    tap_a = (whole > wr_pos_shadow) ? wr_pos_shadow + len_eff - whole : wr_pos_shadow - whole;
    tap_b = (tap_a == 0) ? len_eff - 1 : tap_a - 1;
    near_val = longint'(ring_shadow[tap_a]);
    far_val  = longint'(ring_shadow[tap_b]);

    // Arithmetic shift of the exact product rounds toward minus infinity.
    prod = frac * (far_val - near_val);
    res  = near_val + (prod >>> FRAC_BITS);
    return res[SAMPLE_BITS-1:0];
  endfunction

  // Sample the handshakes, run the shadow model and check each output beat.
  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d samples outstanding.",
               cycle_count, expected_samples.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      in_fired = !rst && in_valid && in_ready;
      if (!rst) begin
        if (cfg_we) length_shadow = cfg_wdata;
        if (out_valid && out_ready) begin
          if (expected_samples.size() == 0) begin
            $error("sample_out: no sample expected, got %0d", sample_out);
            error_count = error_count + 1;
          end else begin
            want = expected_samples.pop_front();
            checked_count = checked_count + 1;
            if (sample_out !== want) begin
              $error("sample_out mismatch: expected %0d, actual %0d", want, sample_out);
              error_count = error_count + 1;
            end
          end
        end
        if (in_fired) expected_samples.push_back(interpolate_tap(sample_in, delay_amount));
      end
    end
  end

  // Input driver: bursts of beats separated by random gaps.
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    delay_beat_t beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        beat = pending_beats.pop_front();
        sample_in    <= beat.smp;
        delay_amount <= beat.dly;
        in_valid     <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          // About one burst in four is long and back to back.
          if ($urandom_range(3, 0) == 0) begin
            burst_left = $urandom_range(60, 20);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(12, 1);
            gap_left   = $urandom_range(6, 0);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall pattern: the mode steps in turn through four patterns, driven by the cycle count.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      case ((cycle_count / 250) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3, 0) != 0);
        2: out_ready <= ($urandom_range(3, 0) == 0);
        default: out_ready <= ((cycle_count % 13) < 8);
      endcase
    end
  end

  task automatic add_beat(input logic signed [SAMPLE_BITS-1:0] smp,
                          input logic [DELAY_BITS-1:0] dly);
    delay_beat_t beat;
    beat.smp = smp;
    beat.dly = dly;
    pending_beats.push_back(beat);
  endtask

  // Wait until no beat is queued, in flight or owed, then let the pipeline settle.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_BITS-1:0] len_raw);
    @(negedge clk);
    cfg_wdata <= len_raw;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    length_writes = length_writes + 1;
  endtask

  // Random beats for one length: mostly in-range delays, some extremes and overflows.
  task automatic add_random_beats(input logic [LEN_BITS-1:0] len_raw, input int count);
    int unsigned                   len_eff;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [DELAY_BITS-1:0]         dly;
    len_eff = clamp_length(len_raw);
    repeat (count) begin
      case ($urandom_range(9, 0))
        0: smp = SAMPLE_MAX;
        1: smp = SAMPLE_MIN;
        2: smp = SAMPLE_BITS'(int'($urandom_range(8, 0)) - 4);
        default: smp = SAMPLE_BITS'($urandom);
      endcase
      case ($urandom_range(9, 0))
        0: dly = DELAY_BITS'($urandom);
        1: dly = DELAY_BITS'((len_eff - 1) << FRAC_BITS);
        2: dly = {WHOLE_BITS'($urandom_range(len_eff - 1, 0)), FRAC_FULL};
        default: dly = DELAY_BITS'(($urandom_range(len_eff - 1, 0) << FRAC_BITS) |
                                   ($urandom & FRAC_FULL));
      endcase
      add_beat(smp, dly);
    end
  endtask

  // Reset, directed beats, then random phases over several ring lengths.
  initial begin
    for (int i = 0; i < MAX_DEPTH; i++) ring_shadow[i] = '0;
    length_shadow = LEN_BITS'(MAX_DEPTH);
    wr_pos_shadow = MAX_DEPTH - 1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The ring is still clearing here, so the write lands while idle.
    write_length(LEN_BITS'(MAX_DEPTH));

    // Directed beats at full length.
    add_beat(SAMPLE_MAX, '0);
    add_beat(SAMPLE_MIN, DELAY_BITS'(FRAC_FULL));
    add_beat(SAMPLE_MAX, DELAY_BITS'(FRAC_FULL));
    add_beat('0, DELAY_BITS'(FRAC_HALF));
    add_beat(-1, DELAY_BITS'(1 << FRAC_BITS));
    add_beat(1, DELAY_BITS'((1 << FRAC_BITS) | FRAC_HALF));
    add_beat(12345, DELAY_BITS'((MAX_DEPTH - 1) << FRAC_BITS));
    add_beat(-12345, DELAY_ALL);
    add_beat(24'sh555555, (DELAY_BITS'(MAX_DEPTH - 2) << FRAC_BITS) | FRAC_FULL);
    add_beat(24'shAAAAAA, DELAY_BITS'(((MAX_DEPTH - 1) << FRAC_BITS) | 1));
    add_beat(SAMPLE_MIN, 1);
    add_beat(SAMPLE_MAX, DELAY_BITS'((2 << FRAC_BITS) | (FRAC_HALF >> 1)));
    add_beat(SAMPLE_MIN, DELAY_BITS'((1 << FRAC_BITS) | FRAC_FULL));
    add_beat(SAMPLE_MAX, DELAY_BITS'((3 << FRAC_BITS) | FRAC_FULL));
    for (int i = 0; i < 6; i++) begin
      add_beat(SAMPLE_BITS'($urandom), DELAY_BITS'((i << FRAC_BITS) | ($urandom & FRAC_FULL)));
    end

    // Shrinking the ring keeps the write position; later phases wrap it.
    wait_idle(); write_length(2);           add_random_beats(2, 70);
    wait_idle(); write_length(0);           add_random_beats(0, 30);
    wait_idle(); write_length(1);           add_random_beats(1, 30);
    wait_idle(); write_length(LEN_BITS'(MAX_DEPTH + 1));
    add_random_beats(LEN_BITS'(MAX_DEPTH + 1), 40);
    wait_idle(); write_length('1);          add_random_beats('1, 90);
    wait_idle(); write_length(3);           add_random_beats(3, 60);
    for (int p = 0; p < 3; p++) begin
      logic [LEN_BITS-1:0] len_pick;
      len_pick = LEN_BITS'($urandom_range(MAX_DEPTH, fdl_pkg::MIN_LENGTH));
      wait_idle(); write_length(len_pick);  add_random_beats(len_pick, 60);
    end
    wait_idle(); write_length(LEN_BITS'(MAX_DEPTH));
    add_random_beats(LEN_BITS'(MAX_DEPTH), 120);
    wait_idle(); write_length(17);          add_random_beats(17, 40);

    wait_idle();
    $display("Checked %0d interpolated samples across %0d ring length settings,",
             checked_count, length_writes);
    $display("including clamped lengths, saturated delays and wrap of the far tap.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
